### src/hhsd_pkg.sv
// Shared types and constants for the hand hold and swipe detector.
// Depends on nothing; every other file of the block imports it.
package hhsd_pkg;

    localparam int COORD_W = 16;
    localparam int RADIUS_W = 15;
    localparam int COUNT_W = 16;
    localparam int TRAIL_W = 4;
    localparam int ENTRY_W = 2 * COORD_W;
    localparam int SQ_W = 32;
    localparam int RSQ_W = 2 * RADIUS_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_Z_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_RADIUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWIPE_RADIUS = 2'd2;

    localparam logic signed [COORD_W-1:0] Z_LIMIT_RESET = 16'sd32767;
    localparam logic [RADIUS_W-1:0] HOLD_RADIUS_RESET = 15'd82;
    localparam logic [RADIUS_W-1:0] SWIPE_RADIUS_RESET = 15'd205;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic
    {
        CMD_SAMPLE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        BTN_NONE = 2'd0,
        BTN_HOVER = 2'd1,
        BTN_HELD = 2'd2
    } btn_t;

    // Classified item as it waits in the queue.
    typedef struct packed
    {
        cmd_t                       cmd;
        logic                       hand;
        logic                       in_range;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic signed [COORD_W-1:0]  button_x;
        logic signed [COORD_W-1:0]  button_y;
        logic [RADIUS_W-1:0]        half_size;
        logic [COUNT_W-1:0]         frames_held;
    } item_t;

    // Item after window issue; the window read data travels beside it.
    typedef struct packed
    {
        item_t                      item;
        logic                       use_zero;
        logic [TRAIL_W-1:0]         trail;
    } issue_t;

    // Item after the squaring stage.
    typedef struct packed
    {
        cmd_t                       cmd;
        logic                       hand;
        logic                       in_range;
        logic                       in_box;
        logic [SQ_W-1:0]            dx2;
        logic [SQ_W-1:0]            dy2;
        logic signed [COORD_W-1:0]  latest_x;
        logic signed [COORD_W-1:0]  latest_y;
        logic [COUNT_W-1:0]         frames_held;
        logic [TRAIL_W-1:0]         trail;
    } calc_t;

endpackage

### src/hhsd_front.sv
// Front end: accepts input transfers, classifies them and queues them.
// Depends on hhsd_pkg.
module hhsd_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                mode,
    input  logic                                hand,
    input  logic signed [hhsd_pkg::COORD_W-1:0] pos_x,
    input  logic signed [hhsd_pkg::COORD_W-1:0] pos_y,
    input  logic signed [hhsd_pkg::COORD_W-1:0] pos_z,
    input  logic signed [hhsd_pkg::COORD_W-1:0] button_x,
    input  logic signed [hhsd_pkg::COORD_W-1:0] button_y,
    input  logic [hhsd_pkg::RADIUS_W-1:0]       button_half_size,
    input  logic [hhsd_pkg::COUNT_W-1:0]        frames_held,
    input  logic signed [hhsd_pkg::COORD_W-1:0] z_limit,
    output logic                                q_valid,
    output hhsd_pkg::item_t                     q_item,
    input  logic                                q_pop
);
    import hhsd_pkg::*;

    item_t      fifo_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;
    item_t      new_item;

    always_comb
    begin
        new_item.cmd = cmd_t'(mode);
        new_item.hand = hand;
        new_item.in_range = (pos_z < z_limit);
        new_item.pos_x = pos_x;
        new_item.pos_y = pos_y;
        new_item.button_x = button_x;
        new_item.button_y = button_y;
        new_item.half_size = button_half_size;
        new_item.frames_held = frames_held;
    end

    assign in_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item = fifo_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop = q_valid && q_pop;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

### src/hhsd_window.sv
// Position windows of both hands: head and fill tracking, window memory,
// and the issue stage that reads the oldest or newest entry. Depends on hhsd_pkg.
module hhsd_window
#(
    parameter int WINDOW_DEPTH = 10
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                q_valid,
    input  hhsd_pkg::item_t                     q_item,
    output logic                                p1_valid,
    output hhsd_pkg::issue_t                    p1,
    output logic [hhsd_pkg::ENTRY_W-1:0]        p1_entry
);
    import hhsd_pkg::*;

    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = $clog2(2 * WINDOW_DEPTH + 1);

    logic [ENTRY_W-1:0] window_mem_reg [2][WINDOW_DEPTH];
    logic [IDX_W-1:0]   head_reg [2];
    logic [IDX_W-1:0]   head_next [2];
    logic [FILL_W-1:0]  fill_reg [2];
    logic [FILL_W-1:0]  fill_next [2];
    logic [1:0]         seed_valid_reg;
    logic [1:0]         seed_valid_next;
    logic               p1_valid_reg;
    issue_t             p1_reg;
    issue_t             p1_next;
    logic [ENTRY_W-1:0] entry_reg;

    logic               issue;
    logic               is_sample;
    logic [IDX_W-1:0]   head_cur;
    logic [FILL_W-1:0]  fill_cur;
    logic [IDX_W-1:0]   head_nx;
    logic [FILL_W-1:0]  fill_nx;
    logic [SUM_W-1:0]   sum;
    logic [IDX_W-1:0]   oldest;
    logic [IDX_W-1:0]   rd_addr;

    assign issue = adv && q_valid;
    assign is_sample = (q_item.cmd == CMD_SAMPLE);
    assign head_cur = head_reg[q_item.hand];
    assign fill_cur = fill_reg[q_item.hand];

    always_comb
    begin
        head_nx = (head_cur == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_cur + IDX_W'(1);
        fill_nx = (fill_cur < FILL_W'(WINDOW_DEPTH)) ? fill_cur + FILL_W'(1) : fill_cur;
        sum = SUM_W'(head_nx) + SUM_W'(1) + SUM_W'(WINDOW_DEPTH) - SUM_W'(fill_nx);
        oldest = (sum >= SUM_W'(WINDOW_DEPTH)) ? IDX_W'(sum - SUM_W'(WINDOW_DEPTH))
                                               : IDX_W'(sum);
        rd_addr = is_sample ? oldest : head_cur;
    end

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        seed_valid_next = seed_valid_reg;
        if (issue && is_sample)
        begin
            head_next[q_item.hand] = head_nx;
            fill_next[q_item.hand] = fill_nx;
            if (head_nx == '0)
            begin
                seed_valid_next[q_item.hand] = 1'b1;
            end
        end
    end

    always_comb
    begin
        p1_next.item = q_item;
        p1_next.use_zero = (rd_addr == '0) && !seed_valid_reg[q_item.hand];
        p1_next.trail = is_sample ? TRAIL_W'(fill_nx) : TRAIL_W'(fill_cur);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg[0] <= '0;
            head_reg[1] <= '0;
            fill_reg[0] <= FILL_W'(1);
            fill_reg[1] <= FILL_W'(1);
            seed_valid_reg <= 2'b00;
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
            seed_valid_reg <= seed_valid_next;
            if (adv)
            begin
                p1_valid_reg <= q_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            p1_reg <= p1_next;
            entry_reg <= window_mem_reg[q_item.hand][rd_addr];
        end
        if (issue && is_sample)
        begin
            window_mem_reg[q_item.hand][head_nx] <= {q_item.pos_x, q_item.pos_y};
        end
    end

    assign p1_valid = p1_valid_reg;
    assign p1 = p1_reg;
    assign p1_entry = entry_reg;

endmodule

### src/hhsd_eval.sv
// Back end: squares the window span, tests the button box, updates the
// per-hand counters and holds the result register. Depends on hhsd_pkg.
module hhsd_eval
(
    input  logic                                clk,
    input  logic                                rst_n,
    output logic                                adv,
    input  logic                                p1_valid,
    input  hhsd_pkg::issue_t                    p1,
    input  logic [hhsd_pkg::ENTRY_W-1:0]        p1_entry,
    input  logic [hhsd_pkg::RADIUS_W-1:0]       hold_radius,
    input  logic [hhsd_pkg::RADIUS_W-1:0]       swipe_radius,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [hhsd_pkg::COUNT_W-1:0]        hold_count,
    output logic [hhsd_pkg::COUNT_W-1:0]        swipe_count,
    output logic [1:0]                          button_state,
    output logic signed [hhsd_pkg::COORD_W-1:0] latest_x,
    output logic signed [hhsd_pkg::COORD_W-1:0] latest_y,
    output logic [hhsd_pkg::TRAIL_W-1:0]        trail_length
);
    import hhsd_pkg::*;

    logic [RSQ_W-1:0]          hr2_reg;
    logic [RSQ_W-1:0]          sr2_reg;
    logic                      p2_valid_reg;
    calc_t                     p2_reg;
    calc_t                     p2_next;
    logic [COUNT_W-1:0]        hold_reg [2];
    logic [COUNT_W-1:0]        hold_next [2];
    logic [COUNT_W-1:0]        swipe_reg [2];
    logic [COUNT_W-1:0]        swipe_next [2];
    logic                      out_valid_reg;
    logic [COUNT_W-1:0]        hold_out_reg;
    logic [COUNT_W-1:0]        swipe_out_reg;
    btn_t                      btn_out_reg;
    logic signed [COORD_W-1:0] x_out_reg;
    logic signed [COORD_W-1:0] y_out_reg;
    logic [TRAIL_W-1:0]        trail_out_reg;

    logic signed [COORD_W-1:0] old_x;
    logic signed [COORD_W-1:0] old_y;
    logic signed [COORD_W:0]   dx;
    logic signed [COORD_W:0]   dy;
    logic signed [2*COORD_W+1:0] dx_sq;
    logic signed [2*COORD_W+1:0] dy_sq;
    logic signed [COORD_W+1:0] t_ext;
    logic signed [COORD_W+1:0] ox_ext;
    logic signed [COORD_W+1:0] oy_ext;
    logic signed [COORD_W+1:0] bx_ext;
    logic signed [COORD_W+1:0] by_ext;

    logic [SQ_W:0]             d2;
    logic [COUNT_W-1:0]        hold_cur;
    logic [COUNT_W-1:0]        swipe_cur;
    logic [COUNT_W-1:0]        hold_upd;
    logic [COUNT_W-1:0]        swipe_upd;
    btn_t                      btn_upd;

    assign adv = !out_valid_reg || out_ready;

    always_comb
    begin
        old_x = p1.use_zero ? '0 : p1_entry[ENTRY_W-1:COORD_W];
        old_y = p1.use_zero ? '0 : p1_entry[COORD_W-1:0];
        dx = (COORD_W+1)'(p1.item.pos_x) - (COORD_W+1)'(old_x);
        dy = (COORD_W+1)'(p1.item.pos_y) - (COORD_W+1)'(old_y);
        dx_sq = (2*COORD_W+2)'(dx) * (2*COORD_W+2)'(dx);
        dy_sq = (2*COORD_W+2)'(dy) * (2*COORD_W+2)'(dy);
        t_ext = signed'({3'b000, p1.item.half_size});
        ox_ext = (COORD_W+2)'(old_x);
        oy_ext = (COORD_W+2)'(old_y);
        bx_ext = (COORD_W+2)'(p1.item.button_x);
        by_ext = (COORD_W+2)'(p1.item.button_y);

        p2_next.cmd = p1.item.cmd;
        p2_next.hand = p1.item.hand;
        p2_next.in_range = p1.item.in_range;
        p2_next.in_box = (oy_ext > by_ext - t_ext) && (oy_ext < by_ext + t_ext)
                      && (ox_ext > bx_ext - t_ext) && (ox_ext < bx_ext + t_ext);
        p2_next.dx2 = dx_sq[SQ_W-1:0];
        p2_next.dy2 = dy_sq[SQ_W-1:0];
        p2_next.latest_x = (p1.item.cmd == CMD_SAMPLE) ? p1.item.pos_x : old_x;
        p2_next.latest_y = (p1.item.cmd == CMD_SAMPLE) ? p1.item.pos_y : old_y;
        p2_next.frames_held = p1.item.frames_held;
        p2_next.trail = p1.trail;
    end

    always_comb
    begin
        d2 = (SQ_W+1)'(p2_reg.dx2) + (SQ_W+1)'(p2_reg.dy2);
        hold_cur = hold_reg[p2_reg.hand];
        swipe_cur = swipe_reg[p2_reg.hand];
        hold_upd = hold_cur;
        swipe_upd = swipe_cur;
        btn_upd = BTN_NONE;
        if (p2_reg.cmd == CMD_SAMPLE)
        begin
            hold_upd = '0;
            swipe_upd = '0;
            if (p2_reg.in_range && (d2 < (SQ_W+1)'(hr2_reg)))
            begin
                hold_upd = (hold_cur == COUNT_MAX) ? hold_cur : hold_cur + COUNT_W'(1);
            end
            else if (p2_reg.in_range && (d2 > (SQ_W+1)'(sr2_reg)))
            begin
                swipe_upd = (swipe_cur == COUNT_MAX) ? swipe_cur : swipe_cur + COUNT_W'(1);
            end
        end
        else if (p2_reg.in_box)
        begin
            btn_upd = (hold_cur > p2_reg.frames_held) ? BTN_HELD : BTN_HOVER;
        end

        hold_next = hold_reg;
        swipe_next = swipe_reg;
        if (adv && p2_valid_reg)
        begin
            hold_next[p2_reg.hand] = hold_upd;
            swipe_next[p2_reg.hand] = swipe_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            hold_reg[0] <= '0;
            hold_reg[1] <= '0;
            swipe_reg[0] <= '0;
            swipe_reg[1] <= '0;
        end
        else
        begin
            hold_reg <= hold_next;
            swipe_reg <= swipe_next;
            if (adv)
            begin
                p2_valid_reg <= p1_valid;
                out_valid_reg <= p2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hr2_reg <= RSQ_W'(hold_radius) * RSQ_W'(hold_radius);
        sr2_reg <= RSQ_W'(swipe_radius) * RSQ_W'(swipe_radius);
        if (adv && p1_valid)
        begin
            p2_reg <= p2_next;
        end
        if (adv && p2_valid_reg)
        begin
            hold_out_reg <= hold_upd;
            swipe_out_reg <= swipe_upd;
            btn_out_reg <= btn_upd;
            x_out_reg <= p2_reg.latest_x;
            y_out_reg <= p2_reg.latest_y;
            trail_out_reg <= p2_reg.trail;
        end
    end

    assign out_valid = out_valid_reg;
    assign hold_count = hold_out_reg;
    assign swipe_count = swipe_out_reg;
    assign button_state = btn_out_reg;
    assign latest_x = x_out_reg;
    assign latest_y = y_out_reg;
    assign trail_length = trail_out_reg;

endmodule

### src/hand_hold_swipe_detector.sv
// Top level of the hand hold and swipe detector: configuration registers,
// front queue, window issue stage and evaluation back end. Depends on hhsd_pkg.
//
// Takes one item per cycle while the result is not stalled: each item needs
// one access to the single-read window memory, so a sample or a query can
// follow in the next cycle. A result passes the queue, the window read and
// the squaring register, then waits in the output register; a two-entry
// queue takes up to two more input transfers while a result is stalled.
// Radius squares are registered from the radius configuration registers.
module hand_hold_swipe_detector
#(
    parameter int WINDOW_DEPTH = 10
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [hhsd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [hhsd_pkg::COORD_W-1:0]          cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  mode,
    input  logic                                  hand,
    input  logic signed [hhsd_pkg::COORD_W-1:0]   pos_x,
    input  logic signed [hhsd_pkg::COORD_W-1:0]   pos_y,
    input  logic signed [hhsd_pkg::COORD_W-1:0]   pos_z,
    input  logic signed [hhsd_pkg::COORD_W-1:0]   button_x,
    input  logic signed [hhsd_pkg::COORD_W-1:0]   button_y,
    input  logic [hhsd_pkg::RADIUS_W-1:0]         button_half_size,
    input  logic [hhsd_pkg::COUNT_W-1:0]          frames_held,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [hhsd_pkg::COUNT_W-1:0]          hold_count,
    output logic [hhsd_pkg::COUNT_W-1:0]          swipe_count,
    output logic [1:0]                            button_state,
    output logic signed [hhsd_pkg::COORD_W-1:0]   latest_x,
    output logic signed [hhsd_pkg::COORD_W-1:0]   latest_y,
    output logic [hhsd_pkg::TRAIL_W-1:0]          trail_length
);
    import hhsd_pkg::*;

    logic signed [COORD_W-1:0] z_limit_reg;
    logic signed [COORD_W-1:0] z_limit_next;
    logic [RADIUS_W-1:0]       hold_radius_reg;
    logic [RADIUS_W-1:0]       hold_radius_next;
    logic [RADIUS_W-1:0]       swipe_radius_reg;
    logic [RADIUS_W-1:0]       swipe_radius_next;

    logic                      adv;
    logic                      q_valid;
    item_t                     q_item;
    logic                      p1_valid;
    issue_t                    p1;
    logic [ENTRY_W-1:0]        p1_entry;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        z_limit_next = z_limit_reg;
        hold_radius_next = hold_radius_reg;
        swipe_radius_next = swipe_radius_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_Z_LIMIT:      z_limit_next = signed'(cfg_data);
                CFG_HOLD_RADIUS:  hold_radius_next = cfg_data[RADIUS_W-1:0];
                CFG_SWIPE_RADIUS: swipe_radius_next = cfg_data[RADIUS_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z_limit_reg <= Z_LIMIT_RESET;
            hold_radius_reg <= HOLD_RADIUS_RESET;
            swipe_radius_reg <= SWIPE_RADIUS_RESET;
        end
        else
        begin
            z_limit_reg <= z_limit_next;
            hold_radius_reg <= hold_radius_next;
            swipe_radius_reg <= swipe_radius_next;
        end
    end

    hhsd_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .hand             (hand),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .pos_z            (pos_z),
        .button_x         (button_x),
        .button_y         (button_y),
        .button_half_size (button_half_size),
        .frames_held      (frames_held),
        .z_limit          (z_limit_reg),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_pop            (adv)
    );

    hhsd_window #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_window
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .p1_valid (p1_valid),
        .p1       (p1),
        .p1_entry (p1_entry)
    );

    hhsd_eval u_eval
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .p1_valid     (p1_valid),
        .p1           (p1),
        .p1_entry     (p1_entry),
        .hold_radius  (hold_radius_reg),
        .swipe_radius (swipe_radius_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hold_count   (hold_count),
        .swipe_count  (swipe_count),
        .button_state (button_state),
        .latest_x     (latest_x),
        .latest_y     (latest_y),
        .trail_length (trail_length)
    );

    a_held_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (button_state == BTN_HELD) |-> (hold_count != '0))
        else $error("held button reported with zero hold count");

    a_counts_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hold_count == '0) || (swipe_count == '0))
        else $error("hold and swipe counts both nonzero");

    a_trail_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (WINDOW_DEPTH > 15)
                   || ((trail_length != '0) && (int'(trail_length) <= WINDOW_DEPTH)))
        else $error("trail length outside window bounds");

    a_issue_under_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(p1_entry))
        else $error("window read data changed while back end stalled");

endmodule
